[rtl/jtq_pkg.sv]
// jtq_pkg: shared types, codes and helpers of the job table queue
// used by job_table_queue and by the bench; no dependencies
package jtq_pkg;

  localparam int JTQ_DEPTH = 16;

  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_REMOVE  = 3'd1;
  localparam logic [2:0] CMD_MODIFY  = 3'd2;
  localparam logic [2:0] CMD_CHANGE  = 3'd3;
  localparam logic [2:0] CMD_PROMOTE = 3'd4;
  localparam logic [2:0] CMD_REORDER = 3'd5;
  localparam logic [2:0] CMD_DUMP_Q  = 3'd6;
  localparam logic [2:0] CMD_DUMP_ID = 3'd7;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_INVALID  = 3'd5;

  localparam logic [2:0] SEL_ID   = 3'd1;
  localparam logic [2:0] SEL_PRIO = 3'd2;
  localparam logic [2:0] SEL_TYPE = 3'd3;
  localparam logic [2:0] SEL_CPU  = 3'd4;
  localparam logic [2:0] SEL_MEM  = 3'd5;

  localparam logic [2:0] FLD_PRIO = 3'd1;
  localparam logic [2:0] FLD_TYPE = 3'd2;
  localparam logic [2:0] FLD_CPU  = 3'd3;
  localparam logic [2:0] FLD_MEM  = 3'd4;

  typedef struct packed {
    logic [31:0] memory;
    logic [31:0] cpu;
    logic [7:0]  jtype;
    logic [7:0]  prio;
    logic [15:0] id;
  } rec_t;

  typedef struct packed {
    logic [1:0]        pad;
    logic [2:0]        sort_key;
    logic signed [7:0] positions;
    logic [31:0]       set_value;
    logic [2:0]        field_select;
    logic [31:0]       memory_used;
    logic [31:0]       cpu_req;
    logic [7:0]        jtype_req;
    logic [7:0]        priority_req;
    logic [15:0]       job_id;
  } req_t;

  typedef struct packed {
    logic [4:0]  occupancy;
    logic [31:0] out_memory;
    logic [31:0] out_cpu;
    logic [7:0]  out_jtype;
    logic [7:0]  out_priority;
    logic [15:0] out_job_id;
    logic [2:0]  status;
  } res_t;

  function automatic logic [31:0] key_of(input logic [2:0] key, input rec_t r);
    logic [31:0] k;
    case (key)
      SEL_ID:   k = {16'd0, r.id};
      SEL_PRIO: k = {24'd0, r.prio};
      SEL_TYPE: k = {24'd0, r.jtype};
      SEL_CPU:  k = r.cpu;
      default:  k = r.memory;
    endcase
    return k;
  endfunction

endpackage

[rtl/jtq_ram.sv]
// jtq_ram: generic single write, single read ram with registered read
// no dependencies
module jtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[rtl/job_table_queue.sv]
// job_table_queue: ordered job table in one record ram, driven by a command sequencer
// depends on jtq_pkg and jtq_ram
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tuser command, s_tdata operands
//  m_       out  m_tvalid/m_tready  m_tdata result, m_tuser has_job, m_tlast
//
// each ram read is registered: a read state issues it and a check state uses the data
// add, modify, change, promote: id scan over the occupied slots, promote then shifts slot by slot
// remove shifts the table down, reorder is a bubble sort, dump id order is a repeated minimum search
// synchronous active-high reset empties the table at once, no clearing pass
// a held result stalls the sequencer only when the next result is ready
module job_table_queue #(
  parameter int QUEUE_DEPTH = jtq_pkg::JTQ_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [2:0]   s_tuser,   // command
  input  logic [143:0] s_tdata,   // job_id, priority_req, jtype_req, cpu_req, memory_used,
                                  // field_select, set_value, positions, sort_key
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [0:0]   m_tuser,   // has_job
  output logic [103:0] m_tdata,   // status, out_job_id, out_priority, out_jtype,
                                  // out_cpu, out_memory, occupancy
  output logic         m_tlast
);
  import jtq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int DW = ((AW > 8) ? AW : 8) + 2;

  typedef enum logic [16:0] {
    S_IDLE     = 17'd1 << 0,
    S_FIND_RD  = 17'd1 << 1,
    S_FIND_CK  = 17'd1 << 2,
    S_RESOLVE  = 17'd1 << 3,
    S_SHIFT_RD = 17'd1 << 4,
    S_SHIFT_WR = 17'd1 << 5,
    S_REM_RD   = 17'd1 << 6,
    S_REM_CK   = 17'd1 << 7,
    S_SORT_LD  = 17'd1 << 8,
    S_SORT_FST = 17'd1 << 9,
    S_SORT_RD  = 17'd1 << 10,
    S_SORT_CK  = 17'd1 << 11,
    S_DUMP_RD  = 17'd1 << 12,
    S_DUMP_EM  = 17'd1 << 13,
    S_MIN_RD   = 17'd1 << 14,
    S_MIN_CK   = 17'd1 << 15,
    S_EMIT     = 17'd1 << 16
  } state_t;

  state_t        state;
  req_t          in_req, req;
  logic [2:0]    command;
  logic [CW-1:0] cnt, idx, emitted;
  logic [AW-1:0] slot, k, tgt, lim, j;
  logic          found, dir_up, best_ok, have_prev;
  rec_t          rec, best, rdata, wdata, in_rec, mod_rec, chg_rec, ld_rec;
  logic [15:0]   prev_id;
  logic [2:0]    res_status, ld_status;
  logic          res_has, ld, ld_has, ld_last;
  logic          ram_we, ram_re;
  logic [AW-1:0] waddr, raddr;
  logic          out_free, gt, fsel_ok, cand;
  logic [CW-1:0] cnt_m1;
  logic signed [DW-1:0] dst, cmax;
  logic [AW-1:0] dst_c;
  res_t          out_res;

  assign in_req   = s_tdata;
  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign cnt_m1   = cnt - CW'(1);

  assign in_rec  = '{memory: req.memory_used, cpu: req.cpu_req, jtype: req.jtype_req,
                     prio: req.priority_req, id: req.job_id};
  assign mod_rec = in_rec;
  assign fsel_ok = (req.field_select == FLD_PRIO) || (req.field_select == FLD_TYPE) ||
                   (req.field_select == FLD_CPU) || (req.field_select == FLD_MEM);
  assign gt   = key_of(req.sort_key, rec) > key_of(req.sort_key, rdata);
  assign cand = (!have_prev || (rdata.id > prev_id)) && (!best_ok || (rdata.id < best.id));

  always_comb begin
    chg_rec = rec;
    case (req.field_select)
      FLD_PRIO: chg_rec.prio   = req.set_value[7:0];
      FLD_TYPE: chg_rec.jtype  = req.set_value[7:0];
      FLD_CPU:  chg_rec.cpu    = req.set_value;
      FLD_MEM:  chg_rec.memory = req.set_value;
      default:  chg_rec = rec;
    endcase
  end

  // promote target, clamped to the occupied range
  always_comb begin
    dst   = $signed({{(DW-AW){1'b0}}, slot}) - $signed({{(DW-8){req.positions[7]}},
                                                       req.positions});
    cmax  = $signed({{(DW-CW){1'b0}}, cnt}) - $signed(DW'(1));
    dst_c = dst[AW-1:0];
    if (dst < 0) begin
      dst_c = '0;
    end else if (dst > cmax) begin
      dst_c = cmax[AW-1:0];
    end
  end

  jtq_ram #(.WIDTH($bits(rec_t)), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (ram_re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    waddr     = '0;
    raddr     = '0;
    wdata     = rec;
    ld        = 1'b0;
    ld_status = ST_OK;
    ld_has    = 1'b0;
    ld_rec    = rec;
    ld_last   = 1'b1;
    unique case (state)
      S_FIND_RD: begin
        if (idx != cnt) begin
          ram_re = 1'b1;
          raddr  = idx[AW-1:0];
        end
      end
      S_RESOLVE: begin
        unique case (command)
          CMD_ADD: begin
            if (!found && cnt != CW'(QUEUE_DEPTH)) begin
              ram_we = 1'b1;
              waddr  = cnt[AW-1:0];
              wdata  = in_rec;
            end
          end
          CMD_MODIFY: begin
            ram_we = found;
            waddr  = slot;
            wdata  = mod_rec;
          end
          CMD_CHANGE: begin
            ram_we = found && fsel_ok;
            waddr  = slot;
            wdata  = chg_rec;
          end
          default: ram_we = 1'b0;
        endcase
      end
      S_SHIFT_RD: begin
        if (k == tgt) begin
          ram_we = 1'b1;
          waddr  = k;
        end else begin
          ram_re = 1'b1;
          raddr  = dir_up ? k + AW'(1) : k - AW'(1);
        end
      end
      S_SHIFT_WR: begin
        ram_we = 1'b1;
        waddr  = k;
        wdata  = rdata;
      end
      S_REM_RD, S_SORT_LD: begin
        ram_re = 1'b1;
      end
      S_SORT_RD: begin
        if (j == lim) begin
          ram_we = 1'b1;
          waddr  = lim;
        end else begin
          ram_re = 1'b1;
          raddr  = j + AW'(1);
        end
      end
      S_SORT_CK: begin
        ram_we = 1'b1;
        waddr  = j;
        wdata  = gt ? rdata : rec;
      end
      S_DUMP_RD: begin
        ram_re = 1'b1;
        raddr  = idx[AW-1:0];
      end
      S_DUMP_EM: begin
        ld      = out_free;
        ld_has  = 1'b1;
        ld_rec  = rdata;
        ld_last = (idx == cnt_m1);
      end
      S_MIN_RD: begin
        if (idx != cnt) begin
          ram_re = 1'b1;
          raddr  = idx[AW-1:0];
        end else begin
          ld      = out_free;
          ld_has  = 1'b1;
          ld_rec  = best;
          ld_last = (emitted == cnt_m1);
        end
      end
      S_EMIT: begin
        ld        = out_free;
        ld_status = res_status;
        ld_has    = res_has;
      end
      default: ld = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req        <= in_req;
            command    <= s_tuser;
            found      <= 1'b0;
            idx        <= '0;
            emitted    <= '0;
            have_prev  <= 1'b0;
            best_ok    <= 1'b0;
            res_status <= ST_OK;
            res_has    <= 1'b0;
            unique case (s_tuser)
              CMD_ADD, CMD_MODIFY, CMD_CHANGE, CMD_PROMOTE: state <= S_FIND_RD;
              CMD_REMOVE: begin
                if (cnt == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_EMIT;
                end else begin
                  state <= S_REM_RD;
                end
              end
              CMD_REORDER: begin
                lim <= cnt_m1[AW-1:0];
                if (cnt < CW'(2)) begin
                  state <= S_EMIT;
                end else if (in_req.sort_key == 3'd0 || in_req.sort_key > SEL_MEM) begin
                  res_status <= ST_INVALID;
                  state      <= S_EMIT;
                end else begin
                  state <= S_SORT_LD;
                end
              end
              default: begin
                if (cnt == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_EMIT;
                end else if (s_tuser == CMD_DUMP_Q) begin
                  state <= S_DUMP_RD;
                end else begin
                  state <= S_MIN_RD;
                end
              end
            endcase
          end
        end
        S_FIND_RD: state <= (idx == cnt) ? S_RESOLVE : S_FIND_CK;
        S_FIND_CK: begin
          if (rdata.id == req.job_id) begin
            found <= 1'b1;
            slot  <= idx[AW-1:0];
            rec   <= rdata;
            state <= S_RESOLVE;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_FIND_RD;
          end
        end
        S_RESOLVE: begin
          state <= S_EMIT;
          if (command != CMD_ADD && !found) begin
            res_status <= ST_NOTFOUND;
          end else begin
            unique case (command)
              CMD_ADD: begin
                if (found) begin
                  res_status <= ST_DUP;
                end else if (cnt == CW'(QUEUE_DEPTH)) begin
                  res_status <= ST_FULL;
                end else begin
                  cnt     <= cnt + CW'(1);
                  rec     <= in_rec;
                  res_has <= 1'b1;
                end
              end
              CMD_MODIFY: begin
                rec     <= mod_rec;
                res_has <= 1'b1;
              end
              CMD_CHANGE: begin
                if (fsel_ok) begin
                  rec     <= chg_rec;
                  res_has <= 1'b1;
                end else begin
                  res_status <= ST_INVALID;
                end
              end
              default: begin
                k       <= slot;
                tgt     <= dst_c;
                dir_up  <= (dst_c > slot);
                res_has <= 1'b1;
                state   <= S_SHIFT_RD;
              end
            endcase
          end
        end
        S_SHIFT_RD: begin
          if (k == tgt) begin
            if (command == CMD_REMOVE) begin
              cnt <= cnt_m1;
            end
            state <= S_EMIT;
          end else begin
            state <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          k     <= dir_up ? k + AW'(1) : k - AW'(1);
          state <= S_SHIFT_RD;
        end
        S_REM_RD: state <= S_REM_CK;
        S_REM_CK: begin
          rec     <= rdata;
          k       <= '0;
          tgt     <= cnt_m1[AW-1:0];
          dir_up  <= 1'b1;
          res_has <= 1'b1;
          state   <= S_SHIFT_RD;
        end
        S_SORT_LD: state <= S_SORT_FST;
        S_SORT_FST: begin
          rec   <= rdata;
          j     <= '0;
          state <= S_SORT_RD;
        end
        S_SORT_RD: begin
          if (j == lim) begin
            if (lim == AW'(1)) begin
              state <= S_EMIT;
            end else begin
              lim   <= lim - AW'(1);
              state <= S_SORT_LD;
            end
          end else begin
            state <= S_SORT_CK;
          end
        end
        S_SORT_CK: begin
          if (!gt) begin
            rec <= rdata;
          end
          j     <= j + AW'(1);
          state <= S_SORT_RD;
        end
        S_DUMP_RD: state <= S_DUMP_EM;
        S_DUMP_EM: begin
          if (out_free) begin
            idx   <= idx + CW'(1);
            state <= (idx == cnt_m1) ? S_IDLE : S_DUMP_RD;
          end
        end
        S_MIN_RD: begin
          if (idx != cnt) begin
            state <= S_MIN_CK;
          end else if (out_free) begin
            prev_id   <= best.id;
            have_prev <= 1'b1;
            best_ok   <= 1'b0;
            idx       <= '0;
            emitted   <= emitted + CW'(1);
            state     <= (emitted == cnt_m1) ? S_IDLE : S_MIN_RD;
          end
        end
        S_MIN_CK: begin
          if (cand) begin
            best    <= rdata;
            best_ok <= 1'b1;
          end
          idx   <= idx + CW'(1);
          state <= S_MIN_RD;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_comb begin
    out_res              = '0;
    out_res.status       = ld_status;
    out_res.occupancy    = cnt[(CW < 5 ? CW : 5)-1:0];
    if (ld_has) begin
      out_res.out_job_id   = ld_rec.id;
      out_res.out_priority = ld_rec.prio;
      out_res.out_jtype    = ld_rec.jtype;
      out_res.out_cpu      = ld_rec.cpu;
      out_res.out_memory   = ld_rec.memory;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ld) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      m_tdata    <= out_res;
      m_tuser[0] <= ld_has;
      m_tlast    <= ld_last;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(QUEUE_DEPTH)) else $error("occupancy beyond depth");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !ram_we) else $error("ram write while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state != S_IDLE) else $error("item accepted but idle");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ld |-> out_free) else $error("result loaded over held item");

endmodule

[bench/tb.sv]
// tb: self-checking bench for job_table_queue, directed table then random commands
// depends on jtq_pkg and the job_table_queue rtl; results checked against a local job table model
`timescale 1ns / 1ps

module tb;
  import jtq_pkg::*;

  typedef struct {
    logic [2:0]  cmd;
    logic [15:0] id;
    logic [7:0]  pr;
    logic [7:0]  ty;
    logic [31:0] cpu;
    logic [31:0] mem;
    logic [2:0]  fsel;
    logic [31:0] nv;
    logic [7:0]  pos;
    logic [2:0]  key;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        has_job;
    logic [15:0] id;
    logic [7:0]  pr;
    logic [7:0]  ty;
    logic [31:0] cpu;
    logic [31:0] mem;
    logic [4:0]  occ;
    logic        last;
  } out_t;

  typedef struct {
    cmd_t       c;
    logic       fixed;
    logic [2:0] st;
    logic [4:0] occ;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [2:0] s_tuser = '0;
  logic [143:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [0:0] m_tuser;
  logic [103:0] m_tdata;
  logic m_tlast;

  job_table_queue u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always #4 clk = ~clk;

  rec_t tbl [JTQ_DEPTH];
  int   njobs;
  out_t results_due[$];
  int   errors = 0;
  int   ready_hold = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic out_t mk(logic [2:0] st, int slot, logic lst);
    out_t o;
    o.status = st;
    o.has_job = slot >= 0;
    o.id = '0; o.pr = '0; o.ty = '0; o.cpu = '0; o.mem = '0;
    if (slot >= 0) begin
      o.id = tbl[slot].id; o.pr = tbl[slot].prio; o.ty = tbl[slot].jtype;
      o.cpu = tbl[slot].cpu; o.mem = tbl[slot].memory;
    end
    o.occ = njobs[4:0];
    o.last = lst;
    return o;
  endfunction

  function automatic logic [31:0] sort_val(logic [2:0] k, rec_t r);
    case (k)
      SEL_ID:   return {16'd0, r.id};
      SEL_PRIO: return {24'd0, r.prio};
      SEL_TYPE: return {24'd0, r.jtype};
      SEL_CPU:  return r.cpu;
      default:  return r.memory;
    endcase
  endfunction

  function automatic int slot_of(logic [15:0] id);
    for (int i = 0; i < njobs; i++) if (tbl[i].id == id) return i;
    return -1;
  endfunction

  // updates the table and queues the results a command causes
  task automatic predict_job_table(cmd_t c);
    int s, d, p;
    int order [JTQ_DEPTH];
    rec_t t;
    out_t o;
    case (c.cmd)
      CMD_ADD: begin
        if (slot_of(c.id) >= 0) results_due.push_back(mk(ST_DUP, -1, 1));
        else if (njobs >= JTQ_DEPTH) results_due.push_back(mk(ST_FULL, -1, 1));
        else begin
          tbl[njobs] = '{memory: c.mem, cpu: c.cpu, jtype: c.ty, prio: c.pr, id: c.id};
          njobs++;
          results_due.push_back(mk(ST_OK, njobs - 1, 1));
        end
      end
      CMD_REMOVE: begin
        if (njobs == 0) results_due.push_back(mk(ST_EMPTY, -1, 1));
        else begin
          o = mk(ST_OK, 0, 1);
          for (int i = 0; i + 1 < njobs; i++) tbl[i] = tbl[i + 1];
          njobs--;
          o.occ = njobs[4:0];
          results_due.push_back(o);
        end
      end
      CMD_MODIFY, CMD_CHANGE: begin
        s = slot_of(c.id);
        if (s < 0) results_due.push_back(mk(ST_NOTFOUND, -1, 1));
        else if (c.cmd == CMD_MODIFY) begin
          tbl[s].prio = c.pr; tbl[s].jtype = c.ty;
          tbl[s].cpu = c.cpu; tbl[s].memory = c.mem;
          results_due.push_back(mk(ST_OK, s, 1));
        end else begin
          case (c.fsel)
            FLD_PRIO: tbl[s].prio = c.nv[7:0];
            FLD_TYPE: tbl[s].jtype = c.nv[7:0];
            FLD_CPU:  tbl[s].cpu = c.nv;
            FLD_MEM:  tbl[s].memory = c.nv;
            default:  s = -2;
          endcase
          if (s == -2) results_due.push_back(mk(ST_INVALID, -1, 1));
          else results_due.push_back(mk(ST_OK, s, 1));
        end
      end
      CMD_PROMOTE: begin
        s = slot_of(c.id);
        if (s < 0) results_due.push_back(mk(ST_NOTFOUND, -1, 1));
        else begin
          p = $signed(c.pos);
          d = s - p;
          if (d < 0) d = 0;
          if (d > njobs - 1) d = njobs - 1;
          t = tbl[s];
          while (s > d) begin tbl[s] = tbl[s - 1]; s--; end
          while (s < d) begin tbl[s] = tbl[s + 1]; s++; end
          tbl[s] = t;
          results_due.push_back(mk(ST_OK, s, 1));
        end
      end
      CMD_REORDER: begin
        if (njobs < 2) results_due.push_back(mk(ST_OK, -1, 1));
        else if (c.key < SEL_ID || c.key > SEL_MEM) results_due.push_back(mk(ST_INVALID, -1, 1));
        else begin
          for (int i = njobs - 1; i > 0; i--)
            for (int j = 0; j < i; j++)
              if (sort_val(c.key, tbl[j]) > sort_val(c.key, tbl[j + 1])) begin
                t = tbl[j]; tbl[j] = tbl[j + 1]; tbl[j + 1] = t;
              end
          results_due.push_back(mk(ST_OK, -1, 1));
        end
      end
      default: begin
        if (njobs == 0) results_due.push_back(mk(ST_EMPTY, -1, 1));
        else begin
          for (int i = 0; i < njobs; i++) order[i] = i;
          if (c.cmd == CMD_DUMP_ID)
            for (int i = 0; i < njobs - 1; i++)
              for (int j = i + 1; j < njobs; j++)
                if (tbl[order[i]].id > tbl[order[j]].id) begin
                  s = order[i]; order[i] = order[j]; order[j] = s;
                end
          for (int i = 0; i < njobs; i++)
            results_due.push_back(mk(ST_OK, order[i], i == njobs - 1));
        end
      end
    endcase
  endtask

  // valid is dropped only before a gap, so back to back items keep it high
  task automatic send_cmd(cmd_t c);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c.cmd;
    s_tdata  <= {2'b00, c.key, c.pos, c.nv, c.fsel, c.mem, c.cpu, c.ty, c.pr, c.id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic cmd_t rnd_cmd(int live_bias);
    cmd_t c;
    int r;
    c.cmd = 3'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    if (r < 20) c.cmd = CMD_ADD;
    c.id = (njobs > 0 && $urandom_range(0, 99) < live_bias) ?
           tbl[$urandom_range(0, njobs - 1)].id :
           ($urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40)));
    c.pr = 8'($urandom); c.ty = 8'($urandom); c.cpu = $urandom; c.mem = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      c.pr = 8'($urandom_range(0, 3)); c.cpu = $urandom_range(0, 3);
    end
    c.fsel = $urandom_range(0, 9) < 8 ? 3'($urandom_range(1, 4)) : 3'($urandom);
    c.nv = $urandom;
    c.pos = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 8) - 4);
    c.key = $urandom_range(0, 9) < 8 ? 3'($urandom_range(1, 5)) : 3'($urandom);
    return c;
  endfunction

  function automatic cmd_t cmd_of(logic [2:0] op, logic [15:0] id, logic [31:0] v,
                                  logic [2:0] sel, logic [7:0] pos);
    cmd_t c;
    c.cmd = op; c.id = id; c.pr = v[7:0]; c.ty = v[15:8]; c.cpu = v; c.mem = ~v;
    c.fsel = sel; c.nv = v; c.pos = pos; c.key = sel;
    return c;
  endfunction

  row_t rows [$];

  initial begin
    cmd_t c;
    njobs = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    rows.push_back('{cmd_of(CMD_REMOVE, 0, 0, 0, 0), 1, ST_EMPTY, 0});
    rows.push_back('{cmd_of(CMD_DUMP_Q, 0, 0, 0, 0), 1, ST_EMPTY, 0});
    rows.push_back('{cmd_of(CMD_DUMP_ID, 0, 0, 0, 0), 1, ST_EMPTY, 0});
    rows.push_back('{cmd_of(CMD_REORDER, 0, 0, 7, 0), 1, ST_OK, 0});
    rows.push_back('{cmd_of(CMD_MODIFY, 5, 0, 0, 0), 1, ST_NOTFOUND, 0});
    rows.push_back('{cmd_of(CMD_ADD, 16'hffff, 32'hffffffff, 0, 0), 1, ST_OK, 1});
    rows.push_back('{cmd_of(CMD_REORDER, 0, 0, 0, 0), 1, ST_OK, 1});
    rows.push_back('{cmd_of(CMD_ADD, 16'hffff, 0, 0, 0), 1, ST_DUP, 1});
    rows.push_back('{cmd_of(CMD_ADD, 0, 0, 0, 0), 0, 0, 0});
    for (int i = 0; i < 15; i++)
      rows.push_back('{cmd_of(CMD_ADD, 16'(100 - i * 3), 32'($urandom), 0, 0), 0, 0, 0});
    rows.push_back('{cmd_of(CMD_ADD, 7, 0, 0, 0), 1, ST_FULL, 16});
    rows.push_back('{cmd_of(CMD_CHANGE, 0, 32'hffffffff, 0, 0), 1, ST_INVALID, 16});
    rows.push_back('{cmd_of(CMD_CHANGE, 1234, 0, FLD_CPU, 0), 1, ST_NOTFOUND, 16});
    rows.push_back('{cmd_of(CMD_CHANGE, 0, 32'habcd1234, FLD_TYPE, 0), 0, 0, 0});
    rows.push_back('{cmd_of(CMD_PROMOTE, 0, 0, 0, 8'sd127), 0, 0, 0});
    rows.push_back('{cmd_of(CMD_PROMOTE, 0, 0, 0, 8'h80), 0, 0, 0});
    rows.push_back('{cmd_of(CMD_REORDER, 0, 0, 6, 0), 1, ST_INVALID, 16});
    rows.push_back('{cmd_of(CMD_REORDER, 0, 0, SEL_ID, 0), 0, 0, 0});
    rows.push_back('{cmd_of(CMD_DUMP_ID, 0, 0, 0, 0), 0, 0, 0});
    rows.push_back('{cmd_of(CMD_DUMP_Q, 0, 0, 0, 0), 0, 0, 0});
    foreach (rows[i]) begin
      predict_job_table(rows[i].c);
      if (rows[i].fixed && (results_due[$].status !== rows[i].st ||
                            results_due[$].occ !== rows[i].occ)) begin
        errors++;
        $display("row %0d: typed status %0d occ %0d, predicted %0d %0d", i, rows[i].st,
                 rows[i].occ, results_due[$].status, results_due[$].occ);
      end
      send_cmd(rows[i].c);
    end
    for (int n = 0; n < 200; n++) begin
      c = rnd_cmd(70);
      // drain now and then so low occupancy and empty cases recur
      if ((n / 40) % 2 == 1 && $urandom_range(0, 2) == 0) c.cmd = CMD_REMOVE;
      predict_job_table(c);
      send_cmd(c);
    end
    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    out_t g, e;
    if (rst) m_tready <= 1'b0;
    else begin
      if (m_tvalid && m_tready) begin
        g.status = m_tdata[2:0]; g.id = m_tdata[18:3]; g.pr = m_tdata[26:19];
        g.ty = m_tdata[34:27]; g.cpu = m_tdata[66:35]; g.mem = m_tdata[98:67];
        g.occ = m_tdata[103:99]; g.has_job = m_tuser[0]; g.last = m_tlast;
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result status %0d id %0h", g.status, g.id);
        end else begin
          e = results_due.pop_front();
          if (g !== e) begin
            errors++;
            if (errors <= 10)
              $display("mismatch exp st%0d h%0d id%h p%h t%h c%h m%h o%0d l%0d / got st%0d h%0d id%h p%h t%h c%h m%h o%0d l%0d",
                       e.status, e.has_job, e.id, e.pr, e.ty, e.cpu, e.mem, e.occ, e.last,
                       g.status, g.has_job, g.id, g.pr, g.ty, g.cpu, g.mem, g.occ, g.last);
          end
        end
      end
      if (ready_hold > 0) begin
        ready_hold <= ready_hold - 1;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        ready_hold <= gap_len();
        m_tready <= 1'b0;
      end else m_tready <= 1'b1;
    end
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
